/* hdl/ppts_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the scheduler.
`default_nettype none
package ppts_pkg;
  localparam int TABLE_SLOTS = 64;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SLOT_W = 6;
  localparam int PID_W = 16;
  localparam int PRIO_W = 7;
  localparam int CHAN_W = 16;
  localparam int ST_W = 3;

  localparam logic [PRIO_W-1:0] PRIO_LIMIT = 7'd100;

  localparam logic [2:0] ACT_CREATE   = 3'd0;
  localparam logic [2:0] ACT_SCHEDULE = 3'd1;
  localparam logic [2:0] ACT_YIELD    = 3'd2;
  localparam logic [2:0] ACT_SLEEP    = 3'd3;
  localparam logic [2:0] ACT_EXIT     = 3'd4;
  localparam logic [2:0] ACT_WAKEUP   = 3'd5;
  localparam logic [2:0] ACT_KILL     = 3'd6;

  localparam logic [ST_W-1:0] ST_UNUSED   = 3'd0;
  localparam logic [ST_W-1:0] ST_SLEEPING = 3'd2;
  localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd3;
  localparam logic [ST_W-1:0] ST_RUNNING  = 3'd4;
  localparam logic [ST_W-1:0] ST_ZOMBIE   = 3'd5;

  localparam logic [1:0] RS_OK   = 2'd0;
  localparam logic [1:0] RS_NONE = 2'd1;
  localparam logic [1:0] RS_IDLE = 2'd2;
  localparam logic [1:0] RS_BUSY = 2'd3;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic point_rd;
    logic finish;
  } ppts_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic run_valid;
  } ppts_stat_t;
endpackage
`default_nettype wire

/* hdl/ppts_ctrl.sv */
// Controller state machine: sequences table scans, single reads and finish.
`default_nettype none
module ppts_ctrl import ppts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [2:0] in_action,
  input  wire ppts_stat_t stat,
  output ppts_cmd_t       cmd,
  output logic            busy
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_POINT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_action) inside
            ACT_CREATE, ACT_WAKEUP, ACT_KILL: state_nxt = S_SCAN;
            ACT_SCHEDULE: state_nxt = stat.run_valid ? S_POINT : S_SCAN;
            ACT_YIELD, ACT_SLEEP, ACT_EXIT: state_nxt = S_POINT;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN:  if (stat.scan_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FIN;
      S_POINT: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cmd.load     = (state_r == S_IDLE) && start;
  assign cmd.scan_rd  = (state_r == S_SCAN);
  assign cmd.point_rd = (state_r == S_POINT);
  assign cmd.finish   = (state_r == S_FIN);
  assign busy         = (state_r != S_IDLE);
endmodule
`default_nettype wire

/* hdl/ppts_dp.sv */
// Datapath: slot table memories, scan evaluation, run state and result registers.
`default_nettype none
module ppts_dp import ppts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ppts_cmd_t         cmd,
  output ppts_stat_t             stat,
  input  wire logic [2:0]        in_action,
  input  wire logic [PRIO_W-1:0] in_priority_req,
  input  wire logic [CHAN_W-1:0] in_channel,
  input  wire logic [PID_W-1:0]  in_target_pid,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [PID_W-1:0]       out_pid
);
  logic [ST_W-1:0]   st_mem   [TABLE_SLOTS];
  logic [PID_W-1:0]  pid_mem  [TABLE_SLOTS];
  logic [PRIO_W-1:0] prio_mem [TABLE_SLOTS];
  logic [CHAN_W-1:0] chan_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] vbit_r;

  logic [2:0]        act_r;
  logic [PRIO_W-1:0] prio_req_r;
  logic [CHAN_W-1:0] chan_r;
  logic [PID_W-1:0]  tpid_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              dv_r;
  logic [IDX_W-1:0]  idx_q;
  logic [ST_W-1:0]   st_q;
  logic              vb_q;
  logic [PID_W-1:0]  pid_q;
  logic [PRIO_W-1:0] prio_q;
  logic [CHAN_W-1:0] chan_q;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [PRIO_W-1:0] best_prio_r;
  logic [PID_W-1:0]  best_pid_r;
  logic              best_sleep_r;
  logic [PID_W-1:0]  next_pid_r;
  logic [IDX_W-1:0]  run_slot_r;
  logic              run_valid_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [PID_W-1:0]  out_pid_r;

  logic [ST_W-1:0]  cur_st;
  logic             hit;
  logic             wake_hit;
  logic [IDX_W-1:0] rd_addr;
  logic             st_we;
  logic [IDX_W-1:0] st_wa;
  logic [ST_W-1:0]  st_wd;
  logic             new_we;
  logic             chan_we;
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_idx;
  logic [PID_W-1:0] res_pid;
  logic             run_clear;
  logic             run_set;

  assign rd_addr = cmd.point_rd ? run_slot_r : cnt_r;
  assign stat.scan_last = (cnt_r == IDX_W'(TABLE_SLOTS - 1));
  assign stat.run_valid = run_valid_r;

  // Registered table read
  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.point_rd) begin
      st_q   <= st_mem[rd_addr];
      vb_q   <= vbit_r[rd_addr];
      pid_q  <= pid_mem[rd_addr];
      prio_q <= prio_mem[rd_addr];
      chan_q <= chan_mem[rd_addr];
      idx_q  <= rd_addr;
    end
  end

  assign cur_st = vb_q ? st_q : ST_UNUSED;

  always_comb begin
    hit = 1'b0;
    case (act_r)
      ACT_CREATE:   hit = (cur_st == ST_UNUSED) && !found_r;
      ACT_SCHEDULE: hit = (cur_st == ST_RUNNABLE) && (prio_q < best_prio_r);
      ACT_KILL:     hit = (cur_st != ST_UNUSED) && (pid_q == tpid_r) && !found_r;
      ACT_WAKEUP:   hit = wake_hit && !found_r;
      default:      hit = 1'b0;
    endcase
  end

  assign wake_hit = dv_r && (act_r == ACT_WAKEUP) && (cur_st == ST_SLEEPING) &&
                    (chan_q == chan_r) && !(run_valid_r && (idx_q == run_slot_r));

  // Finish: decide result and table updates; wakeup state writes also occur during the scan
  always_comb begin
    res_status = RS_NONE;
    res_idx    = '0;
    res_pid    = '0;
    new_we     = 1'b0;
    chan_we    = 1'b0;
    st_we      = wake_hit;
    st_wa      = idx_q;
    st_wd      = ST_RUNNABLE;
    run_clear  = 1'b0;
    run_set    = 1'b0;
    if (cmd.finish) begin
      case (act_r) inside
        ACT_CREATE: begin
          if (found_r) begin
            res_status = RS_OK; res_idx = best_idx_r; res_pid = next_pid_r;
            new_we = 1'b1; st_we = 1'b1; st_wa = best_idx_r; st_wd = ST_RUNNABLE;
          end
        end
        ACT_SCHEDULE: begin
          if (run_valid_r) begin
            res_status = RS_BUSY; res_idx = run_slot_r; res_pid = pid_q;
          end else if (found_r) begin
            res_status = RS_OK; res_idx = best_idx_r; res_pid = best_pid_r;
            st_we = 1'b1; st_wa = best_idx_r; st_wd = ST_RUNNING; run_set = 1'b1;
          end
        end
        ACT_YIELD, ACT_SLEEP, ACT_EXIT: begin
          if (run_valid_r) begin
            res_status = RS_OK; res_idx = run_slot_r; res_pid = pid_q;
            st_we = 1'b1; st_wa = run_slot_r; run_clear = 1'b1;
            st_wd = (act_r == ACT_YIELD) ? ST_RUNNABLE :
                    (act_r == ACT_SLEEP) ? ST_SLEEPING : ST_ZOMBIE;
            chan_we = (act_r == ACT_SLEEP);
          end else begin
            res_status = RS_IDLE;
          end
        end
        ACT_WAKEUP, ACT_KILL: begin
          if (found_r) begin
            res_status = RS_OK; res_idx = best_idx_r; res_pid = best_pid_r;
            if (act_r == ACT_KILL && best_sleep_r) begin
              st_we = 1'b1; st_wa = best_idx_r; st_wd = ST_RUNNABLE;
            end
          end
        end
        default: res_status = RS_NONE;
      endcase
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (new_we) begin
      pid_mem[best_idx_r]  <= next_pid_r;
      prio_mem[best_idx_r] <= prio_req_r;
    end
    if (chan_we) chan_mem[run_slot_r] <= chan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vbit_r <= '0;
    else if (new_we) vbit_r[best_idx_r] <= 1'b1;
  end

  // Transaction capture, scan counter and best-candidate tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r      <= in_action;
      prio_req_r <= in_priority_req;
      chan_r     <= in_channel;
      tpid_r     <= in_target_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      dv_r <= cmd.scan_rd;
      if (cmd.load) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) cnt_r <= cnt_r + 1'b1;
        if (dv_r && hit) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_prio_r <= PRIO_LIMIT;
    end else if (dv_r && hit) begin
      best_idx_r   <= idx_q;
      best_prio_r  <= prio_q;
      best_pid_r   <= pid_q;
      best_sleep_r <= (cur_st == ST_SLEEPING);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pid_r  <= 16'd1;
      run_slot_r  <= '0;
      run_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (new_we) next_pid_r <= next_pid_r + 1'b1;
      if (run_set) begin
        run_slot_r  <= best_idx_r;
        run_valid_r <= 1'b1;
      end else if (run_clear) begin
        run_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_slot_r   <= SLOT_W'(res_idx);
      out_pid_r    <= res_pid;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_pid    = out_pid_r;
endmodule
`default_nettype wire

/* hdl/priority_process_table_scheduler.sv */
// Top level of the process table and priority scheduler.
// Usage:
//  - Drive in_action and its operands and raise start; the transaction is
//    taken at a rising edge where start is high and busy is low.
//  - Each transaction yields one result on out_status/out_slot/out_pid,
//    flagged by out_valid for exactly one cycle; the receiver cannot stall.
//  - Create, wakeup, kill and schedule (with nothing running) sweep the
//    whole slot table through one memory read port, one slot per cycle,
//    then pass through the drain and finish states; out_valid is
//    registered from the finish state.
//  - Schedule while running, yield, sleep and exit do one read of the
//    running slot, then finish. An undefined action goes straight to finish.
//  - busy stays high from accept until the cycle out_valid is shown, so the
//    next transaction can be taken in the same cycle as the result.
//  - No new transaction is taken until the last one finishes; the table sweep takes longest.
//  - Synchronous active-low reset: all slots read unused at once (per-slot
//    valid bits), next pid is one, nothing runs. No clearing pass.
`default_nettype none
module priority_process_table_scheduler import ppts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_action,
  input  wire logic [PRIO_W-1:0] in_priority_req,
  input  wire logic [CHAN_W-1:0] in_channel,
  input  wire logic [PID_W-1:0]  in_target_pid,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [PID_W-1:0]       out_pid
);
  ppts_cmd_t  cmd;
  ppts_stat_t stat;

  // Sequence each transaction
  ppts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the table and evaluate slots
  ppts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_priority_req (in_priority_req),
    .in_channel      (in_channel),
    .in_target_pid   (in_target_pid),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_pid         (out_pid)
  );
endmodule
`default_nettype wire

/* hdl/ppts_checker.sv */
// Port-level checker for the scheduler and its bind.
`default_nettype none
module ppts_checker import ppts_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [1:0]        out_status,
  input wire logic [SLOT_W-1:0] out_slot,
  input wire logic [PID_W-1:0]  out_pid
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not go busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy rose without start");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == RS_NONE || out_status == RS_IDLE) |->
      out_slot == '0 && out_pid == '0) else $error("empty result carries slot or pid");
endmodule

bind priority_process_table_scheduler ppts_checker u_ppts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_slot   (out_slot),
  .out_pid    (out_pid)
);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the process table and priority scheduler.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import ppts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_action = '0;
  logic [PRIO_W-1:0] in_priority_req = '0;
  logic [CHAN_W-1:0] in_channel = '0;
  logic [PID_W-1:0] in_target_pid = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [PID_W-1:0] out_pid;

  always #10 clk = ~clk;

  priority_process_table_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_priority_req(in_priority_req),
    .in_channel(in_channel), .in_target_pid(in_target_pid),
    .out_valid(out_valid), .out_status(out_status), .out_slot(out_slot),
    .out_pid(out_pid)
  );

  typedef struct packed {
    logic [1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0] pid;
  } outcome_t;

  // Shadow copy of the process table.
  logic [ST_W-1:0] tbl_state [TABLE_SLOTS];
  logic [PID_W-1:0] tbl_pid [TABLE_SLOTS];
  logic [PRIO_W-1:0] tbl_prio [TABLE_SLOTS];
  logic [CHAN_W-1:0] tbl_chan [TABLE_SLOTS];
  logic [PID_W-1:0] pid_counter;
  int unsigned cur_slot;
  bit cur_valid;

  outcome_t pending_outcomes[$];
  int unsigned mismatch_count = 0;

  function automatic outcome_t mk(logic [1:0] s, int unsigned i, logic [PID_W-1:0] p);
    outcome_t o;
    o.status = s;
    o.slot = i[SLOT_W-1:0];
    o.pid = p;
    return o;
  endfunction

  // Pull the running process off the CPU into a new state.
  function automatic outcome_t retire_running(logic [ST_W-1:0] ns, logic [CHAN_W-1:0] ch);
    if (!cur_valid) return mk(RS_IDLE, 0, '0);
    tbl_state[cur_slot] = ns;
    if (ns == ST_SLEEPING) tbl_chan[cur_slot] = ch;
    cur_valid = 1'b0;
    return mk(RS_OK, cur_slot, tbl_pid[cur_slot]);
  endfunction

  // Advance the shadow table by one transaction and return its outcome.
  function automatic outcome_t predict_outcome(logic [2:0] act, logic [PRIO_W-1:0] pr,
                                               logic [CHAN_W-1:0] ch, logic [PID_W-1:0] tp);
    int best;
    int first;
    logic [7:0] best_prio;
    best = -1;
    first = -1;
    best_prio = {1'b0, PRIO_LIMIT};
    case (act)
      ACT_CREATE: begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (tbl_state[i] == ST_UNUSED) begin
            tbl_pid[i] = pid_counter;
            pid_counter = pid_counter + 1'b1;
            tbl_prio[i] = pr;
            tbl_state[i] = ST_RUNNABLE;
            return mk(RS_OK, i, tbl_pid[i]);
          end
        return mk(RS_NONE, 0, '0);
      end
      ACT_SCHEDULE: begin
        if (cur_valid) return mk(RS_BUSY, cur_slot, tbl_pid[cur_slot]);
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (tbl_state[i] == ST_RUNNABLE && {1'b0, tbl_prio[i]} < best_prio) begin
            best_prio = {1'b0, tbl_prio[i]};
            best = i;
          end
        if (best < 0) return mk(RS_NONE, 0, '0);
        tbl_state[best] = ST_RUNNING;
        cur_slot = best;
        cur_valid = 1'b1;
        return mk(RS_OK, best, tbl_pid[best]);
      end
      ACT_YIELD: return retire_running(ST_RUNNABLE, '0);
      ACT_SLEEP: return retire_running(ST_SLEEPING, ch);
      ACT_EXIT: return retire_running(ST_ZOMBIE, '0);
      ACT_WAKEUP: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (cur_valid && i == cur_slot) continue;
          if (tbl_state[i] == ST_SLEEPING && tbl_chan[i] == ch) begin
            tbl_state[i] = ST_RUNNABLE;
            if (first < 0) first = i;
          end
        end
        if (first < 0) return mk(RS_NONE, 0, '0);
        return mk(RS_OK, first, tbl_pid[first]);
      end
      ACT_KILL: begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (tbl_state[i] != ST_UNUSED && tbl_pid[i] == tp) begin
            if (tbl_state[i] == ST_SLEEPING) tbl_state[i] = ST_RUNNABLE;
            return mk(RS_OK, i, tbl_pid[i]);
          end
        return mk(RS_NONE, 0, '0);
      end
      default: return mk(RS_NONE, 0, '0);
    endcase
  endfunction

  // Compare every strobed result against the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d slot %0d pid %0d",
                   out_status, out_slot, out_pid);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_status !== want.status || out_slot !== want.slot || out_pid !== want.pid) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected status %0d slot %0d pid %0d, got %0d %0d %0d",
                     want.status, want.slot, want.pid, out_status, out_slot, out_pid);
        end
      end
    end
  end

  // Directed rows: action, priority, channel, pid, whether the outcome is typed in,
  // and the typed outcome.
  typedef struct {
    logic [2:0] act;
    logic [PRIO_W-1:0] pr;
    logic [CHAN_W-1:0] ch;
    logic [PID_W-1:0] tp;
    bit fixed;
    outcome_t want;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{ACT_SCHEDULE, 7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_NONE, 6'd0, 16'd0}},
    '{ACT_YIELD,    7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_IDLE, 6'd0, 16'd0}},
    '{ACT_SLEEP,    7'd0,   16'hFFFF, 16'h0000, 1'b1, '{RS_IDLE, 6'd0, 16'd0}},
    '{ACT_EXIT,     7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_IDLE, 6'd0, 16'd0}},
    '{ACT_KILL,     7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_NONE, 6'd0, 16'd0}},
    '{ACT_WAKEUP,   7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_NONE, 6'd0, 16'd0}},
    '{3'd7,         7'h7F,  16'hFFFF, 16'hFFFF, 1'b1, '{RS_NONE, 6'd0, 16'd0}},
    '{ACT_CREATE,   7'd127, 16'h0000, 16'h0000, 1'b1, '{RS_OK, 6'd0, 16'd1}},
    '{ACT_CREATE,   7'd100, 16'h0000, 16'h0000, 1'b1, '{RS_OK, 6'd1, 16'd2}},
    '{ACT_SCHEDULE, 7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_NONE, 6'd0, 16'd0}},
    '{ACT_CREATE,   7'd99,  16'h0000, 16'h0000, 1'b1, '{RS_OK, 6'd2, 16'd3}},
    '{ACT_CREATE,   7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_OK, 6'd3, 16'd4}},
    '{ACT_CREATE,   7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_OK, 6'd4, 16'd5}},
    '{ACT_SCHEDULE, 7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_OK, 6'd3, 16'd4}},
    '{ACT_SCHEDULE, 7'd0,   16'h0000, 16'h0000, 1'b1, '{RS_BUSY, 6'd3, 16'd4}},
    '{ACT_SLEEP,    7'd0,   16'hFFFF, 16'h0000, 1'b0, '0},
    '{ACT_SCHEDULE, 7'd0,   16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_WAKEUP,   7'd0,   16'hFFFF, 16'h0000, 1'b0, '0},
    '{ACT_SLEEP,    7'd0,   16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_KILL,     7'd0,   16'h0000, 16'h0005, 1'b0, '0},
    '{ACT_SCHEDULE, 7'd0,   16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_EXIT,     7'd0,   16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_KILL,     7'd0,   16'h0000, 16'hFFFF, 1'b0, '0},
    '{ACT_KILL,     7'd0,   16'h0000, 16'h0001, 1'b0, '0},
    '{ACT_YIELD,    7'd0,   16'h0000, 16'h0000, 1'b0, '0}
  };

  bit idle_enable = 1'b1;

  // Present one transaction at the falling edge and hold it until accepted.
  task automatic issue_action(logic [2:0] act, logic [PRIO_W-1:0] pr,
                              logic [CHAN_W-1:0] ch, logic [PID_W-1:0] tp,
                              bit fixed, outcome_t typed);
    outcome_t model;
    model = predict_outcome(act, pr, ch, tp);
    if (fixed && model != typed) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("directed row disagrees with predictor: typed %h, predicted %h", typed, model);
    end
    pending_outcomes.push_back(fixed ? typed : model);
    in_action <= act;
    in_priority_req <= pr;
    in_channel <= ch;
    in_target_pid <= tp;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    // Drop start only for a gap; back-to-back transactions keep it high.
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Channels and pids come mostly from a small pool so that sleep, wakeup and
  // kill meet each other; the rest are full-range noise.
  function automatic logic [CHAN_W-1:0] pick_channel();
    if ($urandom_range(0, 4) == 0) return CHAN_W'($urandom());
    return $urandom_range(0, 3) == 0 ? 16'hFFFF : CHAN_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(0, 4) == 0) return PID_W'($urandom());
    return pid_counter - PID_W'($urandom_range(1, 70));
  endfunction

  initial begin
    int wait_cycles;
    logic [2:0] act;
    int unsigned roll;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_state[i] = ST_UNUSED;
      tbl_pid[i] = '0;
      tbl_prio[i] = '0;
      tbl_chan[i] = '0;
    end
    pid_counter = 16'd1;
    cur_slot = 0;
    cur_valid = 1'b0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k])
      issue_action(directed_rows[k].act, directed_rows[k].pr, directed_rows[k].ch,
                   directed_rows[k].tp, directed_rows[k].fixed, directed_rows[k].want);

    // Random traffic: one fixed mix, heaviest on creates, so the table fills up;
    // it includes a full table and action seven.
    for (int n = 0; n < 400; n++) begin
      if (n > 340) idle_enable = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 22) act = ACT_CREATE;
      else if (roll < 42) act = ACT_SCHEDULE;
      else if (roll < 52) act = ACT_YIELD;
      else if (roll < 64) act = ACT_SLEEP;
      else if (roll < 70) act = ACT_EXIT;
      else if (roll < 84) act = ACT_WAKEUP;
      else if (roll < 97) act = ACT_KILL;
      else act = 3'd7;
      issue_action(act, PRIO_W'($urandom()), pick_channel(), pick_pid(), 1'b0, '0);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_outcomes.size() != 0 && wait_cycles < 1000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (80) @(negedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hold a hard stop well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hdl/ppts_pkg.sv
hdl/ppts_ctrl.sv
hdl/ppts_dp.sv
hdl/priority_process_table_scheduler.sv
hdl/ppts_checker.sv
dv/tb_top.sv
